// ===== rtl/core/tkr_pkg.sv =====
package tkr_pkg;

  localparam int unsigned ListDepth = 100;
  localparam int unsigned RankW     = 7;
  localparam int unsigned CritW     = 32;
  localparam int unsigned CapW      = 22;
  localparam int unsigned EntryW    = 32 + 20 + 24 + 24 + 8 + 20 + 22;

  localparam logic [21:0] CapMax  = 22'h3FFFFF;
  localparam logic [31:0] CritMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ModeVolume = 2'd0,
    ModeLane   = 2'd1,
    ModeRatio  = 2'd2,
    ModeNone   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    StIdle,
    StDiv1,
    StCap,
    StDiv2,
    StTod,
    StDiv3,
    StCrit,
    StScan,
    StShift,
    StWrite,
    StRead,
    StDone
  } state_e;

  typedef struct packed {
    logic [31:0] crit;
    logic [19:0] link;
    logic [23:0] from;
    logic [23:0] to;
    logic [7:0]  period;
    logic [19:0] volume;
    logic [21:0] cap;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture item
    logic div_start;  // launch divider
    logic div_sel1;   // divider operands: 0 capacity, 1 lane-use, 2 criterion
    logic div_sel2;
    logic cap_take;   // capture period capacity
    logic tod_take;   // capture lane-use capacity
    logic crit_take;  // capture criterion
    logic scan_step;  // compare one entry, advance pointer
    logic shift_step; // move one entry down
    logic write_new;  // write new record at pointer
    logic read_ent;   // fetch entry for a read
    logic emit;       // present result
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_read;
    logic skip_early;  // zero volume or capacity
    logic cap_zero;
    logic need_tod;
    logic need_div3;
    logic scan_hit;
    logic scan_end;
    logic shift_end;
    logic need_shift;
  } stat_t;

endpackage

// ===== rtl/core/tkr_div.sv =====
module tkr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] num_i,
  input  logic [39:0] den_i,
  output logic [39:0] quo_o,
  output logic        done_o
);
  logic [39:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [40:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[39]} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd40;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[40]) begin
        rem_d = trial[39:0];
        quo_d = {quo_q[38:0], 1'b1};
      end else begin
        rem_d = {rem_q[38:0], quo_q[39]};
        quo_d = {quo_q[38:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;
endmodule

// ===== rtl/core/tkr_ctrl.sv =====
module tkr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tkr_pkg::stat_t stat_i,
  output tkr_pkg::cmd_t  cmd_o
);
  import tkr_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start_i) state_d = StDiv1;
      StDiv1: begin
        if (stat_i.is_read) state_d = StRead;
        else if (stat_i.skip_early) state_d = StDone;
        else state_d = StCap;
      end
      StCap:   if (stat_i.div_done) state_d = StTod;
      StTod: begin
        if (stat_i.cap_zero) state_d = StDone;
        else if (stat_i.need_tod) state_d = StDiv2;
        else state_d = StCrit;
      end
      StDiv2:  if (stat_i.div_done) state_d = StCrit;
      StCrit:  state_d = stat_i.need_div3 ? StDiv3 : StScan;
      StDiv3:  if (stat_i.div_done) state_d = StScan;
      StScan: begin
        if (stat_i.scan_hit) state_d = stat_i.need_shift ? StShift : StWrite;
        else if (stat_i.scan_end) state_d = StDone;
      end
      StShift: if (stat_i.shift_end) state_d = StWrite;
      StWrite: state_d = StDone;
      StRead:  state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle:  cmd_o.load = start_i;
      StDiv1:  cmd_o.div_start = !stat_i.is_read && !stat_i.skip_early;
      StCap:   cmd_o.cap_take = stat_i.div_done;
      StTod: begin
        cmd_o.div_start = !stat_i.cap_zero && stat_i.need_tod;
        cmd_o.div_sel1  = 1'b1;
        cmd_o.tod_take  = !stat_i.need_tod;
      end
      StDiv2:  cmd_o.tod_take = stat_i.div_done;
      StCrit: begin
        cmd_o.div_start = stat_i.need_div3;
        cmd_o.div_sel2  = 1'b1;
        cmd_o.crit_take = !stat_i.need_div3;
      end
      StDiv3: begin
        cmd_o.div_sel2  = 1'b1;
        cmd_o.crit_take = stat_i.div_done;
      end
      StScan:  cmd_o.scan_step = 1'b1;
      StShift: cmd_o.shift_step = 1'b1;
      StWrite: cmd_o.write_new = 1'b1;
      StRead:  cmd_o.read_ent = 1'b1;
      StDone:  cmd_o.emit = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  ast_emit_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |=> state_q == StIdle) else $error("done not followed by idle");
  ast_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !cmd_o.load) else $error("load while busy");
  ast_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.scan_step, cmd_o.shift_step, cmd_o.write_new, cmd_o.read_ent}))
    else $error("list actions overlap");
endmodule

// ===== rtl/core/tkr_dp.sv =====
module tkr_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tkr_pkg::cmd_t  cmd_i,
  output tkr_pkg::stat_t stat_o,
  input  logic [1:0]     mode_i,
  input  logic [19:0]    hour_i,
  input  logic           operation_i,
  input  logic [19:0]    item_index_i,
  input  logic [23:0]    from_node_i,
  input  logic [23:0]    to_node_i,
  input  logic [7:0]     period_index_i,
  input  logic [19:0]    volume_i,
  input  logic           both_directions_i,
  input  logic [15:0]    hourly_capacity_i,
  input  logic [3:0]     lanes_i,
  input  logic [19:0]    period_length_i,
  input  logic           lane_use_match_i,
  input  logic [4:0]     lane_use_lanes_i,
  output logic           done_o,
  output logic           inserted_o,
  output logic [6:0]     rank_o,
  output logic [31:0]    computed_criteria_o,
  output logic           entry_valid_o,
  output tkr_pkg::entry_t entry_o
);
  import tkr_pkg::*;

  localparam int unsigned PtrW = $clog2(ListDepth + 1);
  localparam logic [PtrW-1:0] Last = PtrW'(ListDepth - 1);

  // Item registers.
  logic        op_q;
  logic [19:0] idx_q, vol_q, plen_q;
  logic [23:0] from_q, to_q;
  logic [7:0]  per_q;
  logic [15:0] hcap_q;
  logic [3:0]  lanes_q;
  logic        match_q;
  logic [4:0]  ulanes_q;
  logic [1:0]  mode_q;
  logic [19:0] hour_q;
  logic [21:0] cap_q, tod_q;
  logic [31:0] crit_q;
  logic [4:0]  tlanes;

  // The list: one memory, one read and one write port.
  entry_t      mem [ListDepth];
  logic [ListDepth-1:0] vld_q;
  entry_t      rd_q;
  logic        rd_vld_q;
  logic [PtrW-1:0] ptr_q, pos_q;
  logic        ins_q;

  logic [39:0] num, den, quo;
  logic        ddone;

  tkr_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(num), .den_i(den),
    .quo_o(quo), .done_o(ddone)
  );

  assign tlanes = match_q ? ulanes_q : {1'b0, lanes_q};

  always_comb begin
    if (cmd_i.div_sel2) begin
      if (mode_q == ModeLane) begin
        num = 40'(vol_q) + 40'(tlanes >> 1);
        den = 40'(tlanes);
      end else begin
        num = 40'(vol_q) * 40'd100 + 40'(tod_q >> 1);
        den = 40'(tod_q);
      end
    end else if (cmd_i.div_sel1) begin
      num = 40'(cap_q) * 40'(ulanes_q) + 40'(lanes_q >> 1);
      den = 40'(lanes_q);
    end else begin
      num = 40'(hcap_q) * 40'(plen_q) + 40'(hour_q >> 1);
      den = 40'(hour_q);
    end
  end

  // Fetch address: scan reads ptr, shift one above it, a read the item index.
  logic [PtrW-1:0] raddr;
  entry_t          newe;
  assign raddr = cmd_i.shift_step ? ptr_q - PtrW'(1) :
                 cmd_i.read_ent ? PtrW'(idx_q) : ptr_q;
  assign newe = '{crit: crit_q, link: idx_q, from: from_q, to: to_q, period: per_q,
                  volume: vol_q, cap: tod_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      idx_q   <= item_index_i;
      from_q  <= from_node_i;
      to_q    <= to_node_i;
      per_q   <= period_index_i;
      vol_q   <= both_directions_i ? (volume_i >> 1) : volume_i;
      hcap_q  <= (volume_i == '0) ? '0 : hourly_capacity_i;
      lanes_q <= (lanes_i == '0) ? 4'd1 : lanes_i;
      plen_q  <= period_length_i;
      match_q <= lane_use_match_i;
      ulanes_q <= lane_use_lanes_i;
      mode_q  <= mode_i;
      hour_q  <= (hour_i == '0) ? 20'd1 : hour_i;
      crit_q  <= '0;
    end
    if (cmd_i.cap_take) cap_q <= (quo > 40'(CapMax)) ? CapMax : quo[21:0];
    if (cmd_i.tod_take) begin
      if (!match_q) tod_q <= cap_q;
      else if (quo == '0) tod_q <= cap_q >> 1;
      else tod_q <= (quo > 40'(CapMax)) ? CapMax : quo[21:0];
    end
    if (cmd_i.crit_take) begin
      unique case (mode_q)
        ModeVolume: crit_q <= 32'(vol_q);
        ModeLane:   crit_q <= (tlanes == '0) ? '0 : quo[31:0];
        ModeRatio:  crit_q <= (tod_q == '0) ? ((vol_q == '0) ? '0 : CritMax) :
                              ((quo > 40'(CritMax)) ? CritMax : quo[31:0]);
        default:    crit_q <= '0;
      endcase
    end
    rd_q <= mem[raddr[$clog2(ListDepth)-1:0]];
    if (cmd_i.shift_step) mem[ptr_q[$clog2(ListDepth)-1:0]] <= rd_q;
    if (cmd_i.write_new)  mem[pos_q[$clog2(ListDepth)-1:0]] <= newe;
  end

  // A shift read lands in the cycle after it is issued, so a shift step moves
  // an entry once its read has landed: ptr walks down from last to hit slot.
  logic shift_prime_q;
  logic hit;
  logic [31:0] cur_crit;
  assign cur_crit = vld_q[ptr_q[$clog2(ListDepth)-1:0]] ? rd_q.crit : '0;
  assign hit = crit_q > cur_crit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ptr_q <= '0;
      pos_q <= '0;
      ins_q <= 1'b0;
      shift_prime_q <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ptr_q <= '0;
        ins_q <= 1'b0;
        shift_prime_q <= 1'b0;
      end
      if (cmd_i.crit_take) ptr_q <= '0;
      if (cmd_i.scan_step) begin
        shift_prime_q <= 1'b1;
        if (shift_prime_q) begin
          if (hit) begin
            pos_q <= ptr_q;
            ptr_q <= Last;
            shift_prime_q <= 1'b0;
          end else begin
            if (ptr_q != Last) ptr_q <= ptr_q + PtrW'(1);
            shift_prime_q <= 1'b0;
          end
        end
      end
      if (cmd_i.shift_step) begin
        shift_prime_q <= 1'b1;
        if (shift_prime_q) begin
          vld_q[ptr_q[$clog2(ListDepth)-1:0]] <= vld_q[ptr_q[$clog2(ListDepth)-1:0] - 1'b1];
          ptr_q <= ptr_q - PtrW'(1);
          shift_prime_q <= 1'b0;
        end
      end
      if (cmd_i.write_new) begin
        vld_q[pos_q[$clog2(ListDepth)-1:0]] <= 1'b1;
        ins_q <= 1'b1;
      end
      if (cmd_i.read_ent) begin
        rd_vld_q <= (idx_q < 20'(ListDepth)) && vld_q[raddr[$clog2(ListDepth)-1:0]];
      end
    end
  end

  always_comb begin
    stat_o = '0;
    stat_o.div_done   = ddone;
    stat_o.is_read    = op_q;
    stat_o.skip_early = (hcap_q == '0);
    stat_o.cap_zero   = (cap_q == '0);
    stat_o.need_tod   = match_q;
    stat_o.need_div3  = (mode_q == ModeLane && tlanes != '0) ||
                        (mode_q == ModeRatio && tod_q != '0);
    stat_o.scan_hit   = shift_prime_q && hit && crit_q != '0;
    stat_o.scan_end   = shift_prime_q && !hit && ptr_q == Last;
    stat_o.need_shift = vld_q[ptr_q[$clog2(ListDepth)-1:0]] && ptr_q != Last;
    stat_o.shift_end  = ptr_q == pos_q;
  end

  // The memory takes a shift write every step; shift_wr marks landed reads.
  logic shift_wr;
  assign shift_wr = cmd_i.shift_step && shift_prime_q;

  assign done_o              = cmd_i.emit;
  assign inserted_o          = ins_q && !op_q;
  assign rank_o              = op_q ? idx_q[6:0] : (ins_q ? pos_q[6:0] : 7'd0);
  assign computed_criteria_o = op_q ? '0 : (hcap_q == '0 || cap_q == '0 ? '0 : crit_q);
  assign entry_valid_o       = op_q && rd_vld_q && rd_q.crit != '0;
  assign entry_o             = (op_q && rd_vld_q) ? rd_q : '0;

  ast_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= Last) else $error("pointer beyond list");
  ast_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_wr |-> ptr_q > pos_q) else $error("shift below insert position");
  ast_write_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_new |-> crit_q != '0) else $error("zero criterion written");
endmodule

// ===== rtl/core/top_k_ratio_ranker.sv =====
// Sequence: a read passes the Div1, Read and Done states before its result
// strobe; an insert runs up to three serial 40-bit divisions (capacity,
// lane-use, criterion), then scans the list and moves entries down.
// One item at a time: start is taken only when idle, so a new item waits for
// the result of the last one. The receiver cannot stall results.
// Reset (rst_ni low, asynchronous) empties the list and restores the
// registers to mode 0 and 36000 ticks per hour.
module top_k_ratio_ranker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  logic        operation_i,
  input  logic [19:0] item_index_i,
  input  logic [23:0] from_node_i,
  input  logic [23:0] to_node_i,
  input  logic [7:0]  period_index_i,
  input  logic [19:0] volume_i,
  input  logic        both_directions_i,
  input  logic [15:0] hourly_capacity_i,
  input  logic [3:0]  lanes_i,
  input  logic [19:0] period_length_i,
  input  logic        lane_use_match_i,
  input  logic [4:0]  lane_use_lanes_i,
  output logic        result_valid_o,
  output logic        inserted_o,
  output logic [6:0]  rank_o,
  output logic [31:0] computed_criteria_o,
  output logic        entry_valid_o,
  output logic [31:0] entry_criteria_o,
  output logic [19:0] entry_link_o,
  output logic [23:0] entry_from_o,
  output logic [23:0] entry_to_o,
  output logic [7:0]  entry_period_o,
  output logic [19:0] entry_volume_o,
  output logic [21:0] entry_capacity_o
);
  import tkr_pkg::*;

  typedef enum logic {
    RegMode = 1'b0,
    RegHour = 1'b1
  } reg_e;

  logic [1:0]  mode_q;
  logic [19:0] hour_q;
  cmd_t        cmd;
  stat_t       stat;
  entry_t      ent;

  // Configuration transfers are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
      hour_q <= 20'd36000;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        RegMode: mode_q <= cfg_data_i[1:0];
        RegHour: hour_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tkr_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .stat_i(stat), .cmd_o(cmd)
  );

  tkr_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .mode_i(mode_q), .hour_i(hour_q),
    .operation_i, .item_index_i, .from_node_i, .to_node_i, .period_index_i,
    .volume_i, .both_directions_i, .hourly_capacity_i, .lanes_i,
    .period_length_i, .lane_use_match_i, .lane_use_lanes_i,
    .done_o(result_valid_o), .inserted_o, .rank_o, .computed_criteria_o,
    .entry_valid_o, .entry_o(ent)
  );

  assign entry_criteria_o = ent.crit;
  assign entry_link_o     = ent.link;
  assign entry_from_o     = ent.from;
  assign entry_to_o       = ent.to;
  assign entry_period_o   = ent.period;
  assign entry_volume_o   = ent.volume;
  assign entry_capacity_o = ent.cap;
endmodule
